/* hdl/least_squares_circle_center_core_defines.svh */
// ---------------------------------------------------------------------------
// least_squares_circle_center_core_defines.svh
// Assertion macros for the circle center fit core.
// ---------------------------------------------------------------------------
`ifndef LEAST_SQUARES_CIRCLE_CENTER_CORE_DEFINES_SVH
`define LEAST_SQUARES_CIRCLE_CENTER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LSCC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lscc assertion failed");

// next-cycle implication
`define LSCC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lscc assertion failed");

`endif

/* hdl/lscc_pkg.sv */
// ---------------------------------------------------------------------------
// lscc_pkg
// Shared constants, codes and sequencing tables of the circle center fit.
// ---------------------------------------------------------------------------
package lscc_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_W        = 16;
    localparam int MIN_POINTS     = 3;
    localparam int QUOT_W         = 17;
    localparam int DSTEP_W        = $clog2(QUOT_W);
    localparam int SAT_POS_MAG    = 32767;
    localparam int SAT_NEG_MAG    = 32768;

    localparam logic [COORD_W-1:0] SAT_POS = 16'h7FFF;
    localparam logic [COORD_W-1:0] SAT_NEG = 16'h8000;

    typedef logic [3:0] ent_t;
    typedef logic [1:0] sys_t;

    // matrix and right-hand-side entries
    localparam ent_t ENT_XX = 4'd0;
    localparam ent_t ENT_XZ = 4'd1;
    localparam ent_t ENT_X  = 4'd2;
    localparam ent_t ENT_ZZ = 4'd3;
    localparam ent_t ENT_Z  = 4'd4;
    localparam ent_t ENT_N  = 4'd5;
    localparam ent_t ENT_BX = 4'd6;
    localparam ent_t ENT_BZ = 4'd7;
    localparam ent_t ENT_BR = 4'd8;

    // which determinant is being expanded
    localparam sys_t SYS_DET  = 2'd0;
    localparam sys_t SYS_NUMX = 2'd1;
    localparam sys_t SYS_NUMZ = 2'd2;

    localparam int TERMS = 6;

    // column picked in a row by one term of the Leibniz expansion
    function automatic logic [1:0] term_col(logic [2:0] term, logic [1:0] row);
        logic [5:0] p;
        case (term)
            3'd0:    p = {2'd2, 2'd1, 2'd0};
            3'd1:    p = {2'd1, 2'd2, 2'd0};
            3'd2:    p = {2'd2, 2'd0, 2'd1};
            3'd3:    p = {2'd0, 2'd2, 2'd1};
            3'd4:    p = {2'd1, 2'd0, 2'd2};
            default: p = {2'd0, 2'd1, 2'd2};
        endcase
        case (row)
            2'd0:    return p[1:0];
            2'd1:    return p[3:2];
            default: return p[5:4];
        endcase
    endfunction

    function automatic logic term_neg(logic [2:0] term);
        logic neg;
        case (term) inside
            3'd1, 3'd2, 3'd5: neg = 1'b1;
            default:          neg = 1'b0;
        endcase
        return neg;
    endfunction

    function automatic ent_t entry_code(sys_t sys, logic [1:0] row, logic [1:0] col);
        ent_t e;
        if ((sys == SYS_NUMX && col == 2'd0) || (sys == SYS_NUMZ && col == 2'd1))
        begin
            case (row)
                2'd0:    e = ENT_BX;
                2'd1:    e = ENT_BZ;
                default: e = ENT_BR;
            endcase
        end
        else
        begin
            case ({row, col})
                4'b0000: e = ENT_XX;
                4'b0001: e = ENT_XZ;
                4'b0010: e = ENT_X;
                4'b0100: e = ENT_XZ;
                4'b0101: e = ENT_ZZ;
                4'b0110: e = ENT_Z;
                4'b1000: e = ENT_X;
                4'b1001: e = ENT_Z;
                default: e = ENT_N;
            endcase
        end
        return e;
    endfunction

endpackage

/* hdl/lscc_if.sv */
// ---------------------------------------------------------------------------
// lscc_if
// Point and center channels: valid/ready with payload.
// ---------------------------------------------------------------------------
interface lscc_point_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lscc_pkg::COORD_W-1:0]   point_x;
    logic signed [lscc_pkg::COORD_W-1:0]   point_z;
    logic                                  last;

    modport source (output valid, point_x, point_z, last, input ready);
    modport sink   (input valid, point_x, point_z, last, output ready);
endinterface

interface lscc_center_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lscc_pkg::COORD_W-1:0]   center_x;
    logic signed [lscc_pkg::COORD_W-1:0]   center_z;
    logic                                  singular;
    logic                                  overflowed;

    modport source (output valid, center_x, center_z, singular, overflowed, input ready);
    modport sink   (input valid, center_x, center_z, singular, overflowed, output ready);
endinterface

/* hdl/least_squares_circle_center_core.sv */
// ---------------------------------------------------------------------------
// least_squares_circle_center_core
// Algebraic least-squares circle fit: moment sums per point, exact 3x3
// solve by Cramer's rule on the last point, rounded and saturated center.
// ---------------------------------------------------------------------------
// A point is taken in one transfer and then runs seven steps through the
// shared 16x34 multiplier that builds the moment sums. A point marked last
// then runs the solve: the three determinants are expanded term by term
// through one shift-add multiplier, one multiplier bit per cycle, and each
// center coordinate takes a 17-step restoring divide. The center is held in
// an output register; the block takes points again once it has been loaded
// there.
// ---------------------------------------------------------------------------

`include "least_squares_circle_center_core_defines.svh"

module least_squares_circle_center_core #(
    parameter int MAX_POINTS = lscc_pkg::MAX_POINTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    lscc_point_if.sink           point,
    lscc_center_if.source        center
);

    localparam int LW     = $clog2(MAX_POINTS);
    localparam int CNT_W  = LW + 1;
    localparam int SX_W   = 16 + LW;
    localparam int SXX_W  = 32 + LW;
    localparam int SR2_W  = 33 + LW;
    localparam int SXR2_W = 48 + LW;
    localparam int R2_W   = 34;
    localparam int PP_W   = lscc_pkg::COORD_W + R2_W;
    localparam int MW     = SXR2_W;
    localparam int BIT_W  = $clog2(MW);
    localparam int DW     = SXR2_W + SXX_W + SX_W + 2;
    localparam int T_W    = DW + lscc_pkg::QUOT_W;
    localparam int CW     = lscc_pkg::COORD_W;
    localparam int ACC_LAST = 6;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_ACC  = 4'd1;
    localparam logic [3:0] ST_CHK  = 4'd2;
    localparam logic [3:0] ST_LDA  = 4'd3;
    localparam logic [3:0] ST_LDB  = 4'd4;
    localparam logic [3:0] ST_MUL0 = 4'd5;
    localparam logic [3:0] ST_LDC  = 4'd6;
    localparam logic [3:0] ST_MUL1 = 4'd7;
    localparam logic [3:0] ST_SEND = 4'd8;
    localparam logic [3:0] ST_DIVA = 4'd9;
    localparam logic [3:0] ST_DIVB = 4'd10;
    localparam logic [3:0] ST_DIVS = 4'd11;
    localparam logic [3:0] ST_DIVF = 4'd12;
    localparam logic [3:0] ST_FIN  = 4'd13;

    logic [3:0]                   state_reg, state_next;
    logic signed [CW-1:0]         x_reg, x_next, z_reg, z_next;
    logic                         last_reg, last_next;
    logic [2:0]                   step_reg, step_next;
    logic signed [PP_W-1:0]       pp_reg, pp_next;
    logic signed [R2_W-1:0]       r2_reg, r2_next;
    logic signed [SX_W-1:0]       sum_x_reg, sum_x_next, sum_z_reg, sum_z_next;
    logic signed [SXX_W-1:0]      sum_xx_reg, sum_xx_next, sum_xz_reg, sum_xz_next;
    logic signed [SXX_W-1:0]      sum_zz_reg, sum_zz_next;
    logic signed [SR2_W-1:0]      sum_r2_reg, sum_r2_next;
    logic signed [SXR2_W-1:0]     sum_xr2_reg, sum_xr2_next, sum_zr2_reg, sum_zr2_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic                         drop_reg, drop_next;

    lscc_pkg::sys_t               sys_reg, sys_next;
    logic [2:0]                   term_reg, term_next;
    logic [BIT_W-1:0]             bit_reg, bit_next;
    logic signed [DW-1:0]         mcand_reg, mcand_next;
    logic signed [MW-1:0]         mplier_reg, mplier_next;
    logic signed [DW-1:0]         prod_reg, prod_next, acc_reg, acc_next;
    logic [DW-1:0]                adet_reg, adet_next, a_reg, a_next;
    logic                         dneg_reg, dneg_next, qneg_reg, qneg_next;
    logic [T_W-1:0]               t_reg, t_next;
    logic [lscc_pkg::QUOT_W-1:0]  q_reg, q_next;
    logic [lscc_pkg::DSTEP_W-1:0] dstep_reg, dstep_next;
    logic [CW-1:0]                cx_reg, cx_next, cz_reg, cz_next;
    logic                         sing_reg, sing_next;

    logic                         out_valid_reg, out_valid_next;
    logic [CW-1:0]                out_x_reg, out_x_next, out_z_reg, out_z_next;
    logic                         out_sing_reg, out_sing_next, out_ovf_reg, out_ovf_next;

    logic signed [CW-1:0]         ma;
    logic signed [R2_W-1:0]       mb;
    logic signed [PP_W-1:0]       pp_prod;
    logic [1:0]                   row_sel;
    lscc_pkg::ent_t               ent;
    logic signed [MW-1:0]         ent_val;
    logic                         sub;
    logic signed [DW-1:0]         addend, prod_step;
    logic [DW-1:0]                acc_abs;
    logic                         ge;
    logic [CW-1:0]                coord;

    // moment multiplier operands
    always_comb
    begin
        case (step_reg)
            3'd0:    begin ma = x_reg; mb = R2_W'(x_reg); end
            3'd1:    begin ma = x_reg; mb = R2_W'(z_reg); end
            3'd2:    begin ma = z_reg; mb = R2_W'(z_reg); end
            3'd5:    begin ma = z_reg; mb = r2_reg;       end
            default: begin ma = x_reg; mb = r2_reg;       end
        endcase
        pp_prod = ma * mb;
    end

    // entry selection for the determinant expansion
    always_comb
    begin
        unique case (state_reg)
            ST_LDB:  row_sel = 2'd1;
            ST_LDC:  row_sel = 2'd2;
            default: row_sel = 2'd0;
        endcase
        ent = lscc_pkg::entry_code(sys_reg, row_sel,
                                   lscc_pkg::term_col(term_reg, row_sel));
        case (ent)
            lscc_pkg::ENT_XX: ent_val = MW'(sum_xx_reg);
            lscc_pkg::ENT_XZ: ent_val = MW'(sum_xz_reg);
            lscc_pkg::ENT_X:  ent_val = MW'(sum_x_reg);
            lscc_pkg::ENT_ZZ: ent_val = MW'(sum_zz_reg);
            lscc_pkg::ENT_Z:  ent_val = MW'(sum_z_reg);
            lscc_pkg::ENT_N:  ent_val = MW'(count_reg);
            lscc_pkg::ENT_BX: ent_val = MW'(sum_xr2_reg);
            lscc_pkg::ENT_BZ: ent_val = MW'(sum_zr2_reg);
            lscc_pkg::ENT_BR: ent_val = MW'(sum_r2_reg);
            default:          ent_val = '0;
        endcase
    end

    // shift-add step, multiplier sign bit weighs negative
    always_comb
    begin
        sub       = (bit_reg == BIT_W'(MW - 1));
        addend    = mcand_reg ^ {DW{sub}};
        prod_step = mplier_reg[0] ? prod_reg + addend + DW'(sub) : prod_reg;
        acc_abs   = acc_reg[DW-1] ? DW'(-acc_reg) : DW'(acc_reg);
        ge        = (T_W'(a_reg) >= t_reg);
        if (qneg_reg)
        begin
            coord = (q_reg > lscc_pkg::QUOT_W'(lscc_pkg::SAT_NEG_MAG)) ?
                    lscc_pkg::SAT_NEG : ~q_reg[CW-1:0] + CW'(1);
        end
        else
        begin
            coord = (q_reg > lscc_pkg::QUOT_W'(lscc_pkg::SAT_POS_MAG)) ?
                    lscc_pkg::SAT_POS : q_reg[CW-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        z_next         = z_reg;
        last_next      = last_reg;
        step_next      = step_reg;
        pp_next        = pp_reg;
        r2_next        = r2_reg;
        sum_x_next     = sum_x_reg;
        sum_z_next     = sum_z_reg;
        sum_xx_next    = sum_xx_reg;
        sum_xz_next    = sum_xz_reg;
        sum_zz_next    = sum_zz_reg;
        sum_r2_next    = sum_r2_reg;
        sum_xr2_next   = sum_xr2_reg;
        sum_zr2_next   = sum_zr2_reg;
        count_next     = count_reg;
        drop_next      = drop_reg;
        sys_next       = sys_reg;
        term_next      = term_reg;
        bit_next       = bit_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        adet_next      = adet_reg;
        a_next         = a_reg;
        dneg_next      = dneg_reg;
        qneg_next      = qneg_reg;
        t_next         = t_reg;
        q_next         = q_reg;
        dstep_next     = dstep_reg;
        cx_next        = cx_reg;
        cz_next        = cz_reg;
        sing_next      = sing_reg;
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_z_next     = out_z_reg;
        out_sing_next  = out_sing_reg;
        out_ovf_next   = out_ovf_reg;

        if (center.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (point.valid)
                begin
                    x_next    = point.point_x;
                    z_next    = point.point_z;
                    last_next = point.last;
                    step_next = '0;
                    if (count_reg < CNT_W'(MAX_POINTS))
                    begin
                        state_next = ST_ACC;
                    end
                    else
                    begin
                        drop_next  = 1'b1;
                        state_next = point.last ? ST_CHK : ST_IDLE;
                    end
                end
            end
            ST_ACC:
            begin
                pp_next   = pp_prod;
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0:
                    begin
                        sum_x_next = sum_x_reg + SX_W'(x_reg);
                        sum_z_next = sum_z_reg + SX_W'(z_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                    3'd1:
                    begin
                        sum_xx_next = sum_xx_reg + SXX_W'(pp_reg);
                        sum_r2_next = sum_r2_reg + SR2_W'(pp_reg);
                        r2_next     = R2_W'(pp_reg);
                    end
                    3'd2: sum_xz_next = sum_xz_reg + SXX_W'(pp_reg);
                    3'd3:
                    begin
                        sum_zz_next = sum_zz_reg + SXX_W'(pp_reg);
                        sum_r2_next = sum_r2_reg + SR2_W'(pp_reg);
                        r2_next     = r2_reg + R2_W'(pp_reg);
                    end
                    3'd5: sum_xr2_next = sum_xr2_reg + SXR2_W'(pp_reg);
                    3'd6: sum_zr2_next = sum_zr2_reg + SXR2_W'(pp_reg);
                    default: ;
                endcase
                if (step_reg == 3'(ACC_LAST))
                begin
                    state_next = last_reg ? ST_CHK : ST_IDLE;
                end
            end
            ST_CHK:
            begin
                cx_next   = '0;
                cz_next   = '0;
                sing_next = 1'b0;
                if (count_reg < CNT_W'(lscc_pkg::MIN_POINTS))
                begin
                    sing_next  = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    sys_next   = lscc_pkg::SYS_DET;
                    term_next  = '0;
                    acc_next   = '0;
                    state_next = ST_LDA;
                end
            end
            ST_LDA:
            begin
                mcand_next = DW'(ent_val);
                state_next = ST_LDB;
            end
            ST_LDB:
            begin
                mplier_next = ent_val;
                prod_next   = '0;
                bit_next    = '0;
                state_next  = ST_MUL0;
            end
            ST_MUL0:
            begin
                prod_next   = prod_step;
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >>> 1;
                bit_next    = bit_reg + BIT_W'(1);
                if (sub)
                begin
                    state_next = ST_LDC;
                end
            end
            ST_LDC:
            begin
                mcand_next  = lscc_pkg::term_neg(term_reg) ? -prod_reg : prod_reg;
                mplier_next = ent_val;
                prod_next   = acc_reg;
                bit_next    = '0;
                state_next  = ST_MUL1;
            end
            ST_MUL1:
            begin
                prod_next   = prod_step;
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >>> 1;
                bit_next    = bit_reg + BIT_W'(1);
                if (sub)
                begin
                    acc_next = prod_step;
                    if (term_reg == 3'(lscc_pkg::TERMS - 1))
                    begin
                        state_next = ST_SEND;
                    end
                    else
                    begin
                        term_next  = term_reg + 3'd1;
                        state_next = ST_LDA;
                    end
                end
            end
            ST_SEND:
            begin
                if (sys_reg == lscc_pkg::SYS_DET)
                begin
                    if (acc_reg == '0)
                    begin
                        sing_next  = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        adet_next  = acc_abs;
                        dneg_next  = acc_reg[DW-1];
                        sys_next   = lscc_pkg::SYS_NUMX;
                        term_next  = '0;
                        acc_next   = '0;
                        state_next = ST_LDA;
                    end
                end
                else
                begin
                    state_next = ST_DIVA;
                end
            end
            ST_DIVA:
            begin
                a_next     = acc_abs;
                qneg_next  = acc_reg[DW-1] ^ dneg_reg;
                q_next     = '0;
                state_next = ST_DIVB;
            end
            ST_DIVB:
            begin
                a_next     = a_reg + adet_reg;
                t_next     = T_W'(adet_reg) << lscc_pkg::QUOT_W;
                dstep_next = '0;
                state_next = ST_DIVS;
            end
            ST_DIVS:
            begin
                if (ge)
                begin
                    a_next = a_reg - DW'(t_reg);
                end
                q_next     = {q_reg[lscc_pkg::QUOT_W-2:0], ge};
                t_next     = t_reg >> 1;
                dstep_next = dstep_reg + lscc_pkg::DSTEP_W'(1);
                if (dstep_reg == lscc_pkg::DSTEP_W'(lscc_pkg::QUOT_W - 1))
                begin
                    state_next = ST_DIVF;
                end
            end
            ST_DIVF:
            begin
                if (sys_reg == lscc_pkg::SYS_NUMX)
                begin
                    cx_next    = coord;
                    sys_next   = lscc_pkg::SYS_NUMZ;
                    term_next  = '0;
                    acc_next   = '0;
                    state_next = ST_LDA;
                end
                else
                begin
                    cz_next    = coord;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || center.ready)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = cx_reg;
                    out_z_next     = cz_reg;
                    out_sing_next  = sing_reg;
                    out_ovf_next   = drop_reg;
                    sum_x_next     = '0;
                    sum_z_next     = '0;
                    sum_xx_next    = '0;
                    sum_xz_next    = '0;
                    sum_zz_next    = '0;
                    sum_r2_next    = '0;
                    sum_xr2_next   = '0;
                    sum_zr2_next   = '0;
                    count_next     = '0;
                    drop_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            sum_x_reg     <= '0;
            sum_z_reg     <= '0;
            sum_xx_reg    <= '0;
            sum_xz_reg    <= '0;
            sum_zz_reg    <= '0;
            sum_r2_reg    <= '0;
            sum_xr2_reg   <= '0;
            sum_zr2_reg   <= '0;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            sys_reg       <= lscc_pkg::SYS_DET;
            term_reg      <= '0;
            bit_reg       <= '0;
            dstep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            sum_x_reg     <= sum_x_next;
            sum_z_reg     <= sum_z_next;
            sum_xx_reg    <= sum_xx_next;
            sum_xz_reg    <= sum_xz_next;
            sum_zz_reg    <= sum_zz_next;
            sum_r2_reg    <= sum_r2_next;
            sum_xr2_reg   <= sum_xr2_next;
            sum_zr2_reg   <= sum_zr2_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            sys_reg       <= sys_next;
            term_reg      <= term_next;
            bit_reg       <= bit_next;
            dstep_reg     <= dstep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        z_reg        <= z_next;
        last_reg     <= last_next;
        pp_reg       <= pp_next;
        r2_reg       <= r2_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        adet_reg     <= adet_next;
        a_reg        <= a_next;
        dneg_reg     <= dneg_next;
        qneg_reg     <= qneg_next;
        t_reg        <= t_next;
        q_reg        <= q_next;
        cx_reg       <= cx_next;
        cz_reg       <= cz_next;
        sing_reg     <= sing_next;
        out_x_reg    <= out_x_next;
        out_z_reg    <= out_z_next;
        out_sing_reg <= out_sing_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign point.ready       = (state_reg == ST_IDLE);
    assign center.valid      = out_valid_reg;
    assign center.center_x   = out_x_reg;
    assign center.center_z   = out_z_reg;
    assign center.singular   = out_sing_reg;
    assign center.overflowed = out_ovf_reg;

    `LSCC_ASSERT_IMP(a_count_cap, 1'b1, count_reg <= CNT_W'(MAX_POINTS))
    `LSCC_ASSERT_NXT(a_point_acc, point.valid && point.ready && count_reg < CNT_W'(MAX_POINTS), state_reg == ST_ACC)
    `LSCC_ASSERT_IMP(a_sing_zero, center.valid && center.singular, center.center_x == '0 && center.center_z == '0)
    `LSCC_ASSERT_IMP(a_div_det, state_reg == ST_DIVS, adet_reg != '0)

endmodule

/* bench/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Testbench of least_squares_circle_center_core. It sends runs of points,
// some on circles and some random, collinear or repeated, plus sets that
// run over capacity. For every set it works out the fitted center exactly
// with wide integer arithmetic and checks each center transfer, field by
// field, in order. Both channels idle in random bursts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int  CAPACITY   = lscc_pkg::MAX_POINTS_DEF;
    localparam int  ITEM_COUNT = 1350;
    localparam int  CALM_ITEMS = 150;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef logic signed [255:0] wide_t;
    typedef logic signed [lscc_pkg::COORD_W-1:0] coord_t;

    typedef struct {
        coord_t cx;
        coord_t cz;
        logic   sing;
        logic   ovf;
    } center_t;

    class circle_fit_board;
        longint  s_x, s_z, s_xx, s_xz, s_zz, s_xr2, s_zr2, s_r2;
        int      kept;
        bit      dropped;
        center_t centers_due[$];
        int      errors;

        function new();
            errors = 0;
            clear_sums();
        endfunction

        function void clear_sums();
            s_x = 0; s_z = 0; s_xx = 0; s_xz = 0; s_zz = 0;
            s_xr2 = 0; s_zr2 = 0; s_r2 = 0;
            kept = 0;
            dropped = 0;
        endfunction

        function wide_t det3(wide_t a0, wide_t a1, wide_t a2, wide_t a3, wide_t a4,
                             wide_t a5, wide_t a6, wide_t a7, wide_t a8);
            return a0 * (a4 * a8 - a5 * a7) - a1 * (a3 * a8 - a5 * a6)
                 + a2 * (a3 * a7 - a4 * a6);
        endfunction

        // round(num / (2*det)), ties away from zero, then saturate
        function coord_t half_ratio(wide_t num, wide_t det);
            logic [255:0] an, ad, q;
            bit neg;
            neg = (num < 0) != (det < 0);
            an = (num < 0) ? -num : num;
            ad = (det < 0) ? -det : det;
            if (an == 0)
                return '0;
            q = (an + ad) / (ad << 1);
            if (neg)
                return (q > lscc_pkg::SAT_NEG_MAG) ? lscc_pkg::SAT_NEG : coord_t'(-q);
            return (q > lscc_pkg::SAT_POS_MAG) ? lscc_pkg::SAT_POS : coord_t'(q);
        endfunction

        function void note_point(coord_t px, coord_t pz, logic lst);
            longint x, z, r2;
            wide_t xx, xz, xs, zz, zs, n, bx, bz, br, det;
            center_t c;
            x = px;
            z = pz;
            if (kept < CAPACITY)
            begin
                r2 = x * x + z * z;
                s_x += x; s_z += z;
                s_xx += x * x; s_xz += x * z; s_zz += z * z;
                s_r2 += r2; s_xr2 += x * r2; s_zr2 += z * r2;
                kept++;
            end
            else
                dropped = 1;
            if (!lst)
                return;
            c.cx = '0; c.cz = '0; c.sing = 1'b1; c.ovf = dropped;
            if (kept >= lscc_pkg::MIN_POINTS)
            begin
                xx = s_xx; xz = s_xz; xs = s_x; zz = s_zz; zs = s_z; n = kept;
                bx = s_xr2; bz = s_zr2; br = s_r2;
                det = det3(xx, xz, xs, xz, zz, zs, xs, zs, n);
                if (det != 0)
                begin
                    c.sing = 1'b0;
                    c.cx = half_ratio(det3(bx, xz, xs, bz, zz, zs, br, zs, n), det);
                    c.cz = half_ratio(det3(xx, bx, xs, xz, bz, zs, xs, br, n), det);
                end
            end
            centers_due.insert(centers_due.size(), c);
            clear_sums();
        endfunction

        function void check_center(coord_t cx, coord_t cz, logic sing, logic ovf);
            center_t e;
            if (centers_due.size() == 0)
            begin
                $error("center transfer with none expected");
                errors++;
                return;
            end
            e = centers_due.pop_front();
            if (cx !== e.cx)
            begin
                $error("center_x expected %0d actual %0d", e.cx, cx);
                errors++;
            end
            if (cz !== e.cz)
            begin
                $error("center_z expected %0d actual %0d", e.cz, cz);
                errors++;
            end
            if (sing !== e.sing)
            begin
                $error("singular expected %0b actual %0b", e.sing, sing);
                errors++;
            end
            if (ovf !== e.ovf)
            begin
                $error("overflowed expected %0b actual %0b", e.ovf, ovf);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    longint cycles;
    bit idle_on;
    int sent;

    lscc_point_if  pt();
    lscc_center_if cv();

    circle_fit_board fit;

    least_squares_circle_center_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (pt.sink),
        .center (cv.source)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[least_squares_circle_center_core] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cv.valid && cv.ready)
            fit.check_center(cv.center_x, cv.center_z, cv.singular, cv.overflowed);
    end

    initial
    begin
        cv.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                cv.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            cv.ready <= 1'b1;
        end
    end

    function automatic coord_t clamp16(int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return coord_t'(v);
    endfunction

    task automatic send_point(coord_t x, coord_t z, logic lst);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            pt.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        pt.valid   <= 1'b1;
        pt.point_x <= x;
        pt.point_z <= z;
        pt.last    <= lst;
        @(posedge clk);
        while (!pt.ready)
            @(posedge clk);
        fit.note_point(x, z, lst);
        sent++;
        if (sent >= ITEM_COUNT - CALM_ITEMS)
            idle_on = 0;
        @(negedge clk);
    endtask

    // kinds: 0 full range, 1 near a circle, 2 collinear, 3 one repeated point
    task automatic send_set(int n, int kind);
        int cx, cz, r, dx, dz, sx, sz, x0, z0;
        cx = $signed($urandom_range(0, 16000)) - 8000;
        cz = $signed($urandom_range(0, 16000)) - 8000;
        r  = $urandom_range(20, 9000);
        sx = $signed($urandom_range(0, 400)) - 200;
        sz = $signed($urandom_range(0, 400)) - 200;
        x0 = $signed($urandom_range(0, 65535)) - 32768;
        z0 = $signed($urandom_range(0, 65535)) - 32768;
        for (int i = 0; i < n; i++)
        begin
            case (kind)
                0: send_point(coord_t'($urandom), coord_t'($urandom), i == n - 1);
                1:
                begin
                    dx = $signed($urandom_range(0, 2 * r)) - r;
                    dz = int'($sqrt(real'(r) * r - real'(dx) * dx));
                    if ($urandom_range(0, 1))
                        dz = -dz;
                    send_point(clamp16(cx + dx + $urandom_range(0, 6) - 3),
                               clamp16(cz + dz + $urandom_range(0, 6) - 3), i == n - 1);
                end
                2: send_point(clamp16(cx + i * sx), clamp16(cz + i * sz), i == n - 1);
                default: send_point(coord_t'(x0), coord_t'(z0), i == n - 1);
            endcase
        end
    endtask

    initial
    begin
        int n, kind;
        fit = new();
        cycles = 0;
        sent = 0;
        idle_on = 0;
        rst_n = 1'b0;
        pt.valid = 1'b0;
        pt.point_x = '0;
        pt.point_z = '0;
        pt.last = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // extremes of the coordinates
        send_point(16'sh8000, 16'sh8000, 1'b0);
        send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_point(16'sh8000, 16'sh7FFF, 1'b1);
        send_point(16'sh7FFF, 16'sh8000, 1'b0);
        send_point(16'sh0000, 16'sh0000, 1'b0);
        send_point(16'sh7FFF, 16'sh7FFF, 1'b1);
        // too few points
        send_point(16'sh0400, 16'sh0000, 1'b1);
        send_point(16'sh0400, 16'sh0000, 1'b0);
        send_point(16'sh0000, 16'sh0400, 1'b1);
        // collinear
        send_set(4, 2);
        // circle of radius 1024 centered at the origin, and a tiny one far away
        send_point(16'sh0400, 16'sh0000, 1'b0);
        send_point(16'sh0000, 16'sh0400, 1'b0);
        send_point(-16'sh0400, 16'sh0000, 1'b1);
        send_point(16'sh7FFF, 16'sh7FFE, 1'b0);
        send_point(16'sh7FFE, 16'sh7FFF, 1'b0);
        send_point(16'sh7FFF, 16'sh7FFF, 1'b1);
        // over capacity, last two points dropped
        send_set(CAPACITY + 2, 1);
        // exactly at capacity
        send_set(CAPACITY, 0);

        idle_on = 1;
        while (sent < ITEM_COUNT)
        begin
            kind = $urandom_range(0, 9);
            kind = (kind < 5) ? 1 : (kind < 8) ? 0 : (kind == 8) ? 2 : 3;
            if ($urandom_range(0, 19) == 0)
                n = $urandom_range(CAPACITY - 2, CAPACITY + 6);
            else
                n = $urandom_range(1, 12);
            send_set(n, kind);
        end
        pt.valid <= 1'b0;

        while (fit.centers_due.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fit.errors == 0)
            $display("[least_squares_circle_center_core] OK");
        else
            $display("[least_squares_circle_center_core] ERROR");
        $finish;
    end

endmodule

/* least_squares_circle_center_core.f */
+incdir+hdl
hdl/lscc_pkg.sv
hdl/lscc_if.sv
hdl/least_squares_circle_center_core.sv
bench/tb_top.sv
